// ----- rtl/idba_pkg.sv -----
// Shared constants and operation codes for the identifier bitmap allocator.
`default_nettype none

package idba_pkg;

	// Map geometry
	localparam int MAP_BYTES = 256;
	localparam int BYTE_W = 8;
	localparam int ID_W = 11;
	localparam int OP_W = 3;
	localparam int ID_FIELD_BYTES = (1 << ID_W) / BYTE_W;
	localparam int SCAN_BYTES = (MAP_BYTES < ID_FIELD_BYTES) ? MAP_BYTES : ID_FIELD_BYTES;
	localparam int ADDR_W = $clog2(MAP_BYTES);
	localparam int PTR_W = $clog2(SCAN_BYTES);
	localparam int BIT_W = $clog2(BYTE_W);

	// Byte values
	localparam logic [BYTE_W-1:0] BYTE_FULL = 8'hFF;
	localparam logic [BYTE_W-1:0] BYTE_ID0 = 8'h01;
	localparam logic [BYTE_W-1:0] BYTE_EMPTY = 8'h00;

	// Operation codes
	typedef enum logic [OP_W-1:0] {
		OP_CLEAR   = 3'd0,
		OP_CLAIM   = 3'd1,
		OP_RELEASE = 3'd2,
		OP_FIND_LO = 3'd3,
		OP_FIND_HI = 3'd4
	} op_t;

endpackage

`default_nettype wire

// ----- rtl/idba_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module idba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/id_bitmap_allocator.sv -----
// Top level of the identifier bitmap allocator: control sequencer around the map RAM.
//
//  channel | direction | handshake           | fields
//  --------+-----------+---------------------+---------------------------
//  in      | input     | in_valid / in_ready | op[2:0], ident[10:0]
//  out     | output    | out_valid/out_ready | found_ident[10:0], ok
//
// Clear goes straight to output; claim and release do one RAM read, then write-back.
// Find-lowest and find-highest read one map byte per cycle through the single
// RAM read port, and the scan stops at the first byte with a free bit.
// One item is in work at a time.
// Reset and clear drop all per-byte valid bits, so unwritten bytes read as the
// empty map (id 0 taken) at once; there is no clearing pass.
// A stalled result holds in the output register; the next item is taken
// while it waits.
`default_nettype none

module id_bitmap_allocator (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic [idba_pkg::OP_W-1:0] op,
	input  wire logic [idba_pkg::ID_W-1:0] ident,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic      [idba_pkg::ID_W-1:0] found_ident,
	output logic                         ok
);

	import idba_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RMW,
		ST_SCAN,
		ST_OUT
	} state_t;

	state_t              state_q;
	logic [MAP_BYTES-1:0] valid_q;
	logic                op_claim_q;
	logic [BIT_W-1:0]    bit_q;
	logic                in_map_q;
	logic                hi_q;
	logic [PTR_W-1:0]    scan_ptr_q;
	logic                issue_done_q;
	logic                scan_vld_s1;
	logic                scan_last_s1;
	logic [ADDR_W-1:0]   rd_addr_s1;
	logic [ID_W-1:0]     res_found_q;
	logic                res_ok_q;
	logic                out_valid_q;
	logic [ID_W-1:0]     found_ident_q;
	logic                ok_q;

	logic [ADDR_W-1:0]   raddr;
	logic [BYTE_W-1:0]   rdata;
	logic                ram_we;
	logic [BYTE_W-1:0]   ram_wdata;
	logic [BYTE_W-1:0]   byte_eff;
	logic [BYTE_W-1:0]   hi_byte;
	logic [BYTE_W-1:0]   bit_mask;
	logic                bit_taken;
	logic                lo_hit;
	logic                hi_hit;
	logic                scan_hit;
	logic [BIT_W-1:0]    lo_bit;
	logic [BIT_W-1:0]    hi_bit;
	logic [ID_W-1:0]     scan_found;
	logic [PTR_W-1:0]    scan_end;
	logic [ID_W-BIT_W-1:0] ident_byte;

	// Lowest clear bit of a byte
	function automatic logic [BIT_W-1:0] lowest_zero(input logic [BYTE_W-1:0] b);
		logic [BIT_W-1:0] r;
		r = '0;
		for (int j = BYTE_W - 1; j >= 0; j--) begin
			if (!b[j]) r = BIT_W'(j);
		end
		return r;
	endfunction

	// Highest clear bit of a byte
	function automatic logic [BIT_W-1:0] highest_zero(input logic [BYTE_W-1:0] b);
		logic [BIT_W-1:0] r;
		r = '0;
		for (int j = 0; j < BYTE_W; j++) begin
			if (!b[j]) r = BIT_W'(j);
		end
		return r;
	endfunction

	idba_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(MAP_BYTES)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (rd_addr_s1),
		.wdata (ram_wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign ident_byte = ident[ID_W-1:BIT_W];

	// Read address: the item's byte when idle, the scan pointer while scanning
	always_comb begin
		if (state_q == ST_SCAN) begin
			raddr = ADDR_W'(scan_ptr_q);
		end else begin
			raddr = ADDR_W'(ident_byte);
		end
	end

	// Byte as seen by the map: unwritten bytes hold their cleared value
	always_comb begin
		if (valid_q[rd_addr_s1]) begin
			byte_eff = rdata;
		end else if (rd_addr_s1 == '0) begin
			byte_eff = BYTE_ID0;
		end else begin
			byte_eff = BYTE_EMPTY;
		end
	end

	// Read-modify-write for claim and release
	assign bit_mask = BYTE_W'(1) << bit_q;
	assign bit_taken = |(byte_eff & bit_mask);
	always_comb begin
		ram_we = 1'b0;
		ram_wdata = byte_eff & ~bit_mask;
		if (state_q == ST_RMW && in_map_q) begin
			if (op_claim_q) begin
				ram_we = !bit_taken;
				ram_wdata = byte_eff | bit_mask;
			end else begin
				ram_we = 1'b1;
			end
		end
	end

	// Free-bit search in the byte returned to the scan; bit 0 ignored going down
	assign hi_byte = byte_eff | BYTE_ID0;
	assign lo_hit = byte_eff != BYTE_FULL;
	assign hi_hit = hi_byte != BYTE_FULL;
	assign lo_bit = lowest_zero(byte_eff);
	assign hi_bit = highest_zero(hi_byte);
	assign scan_hit = hi_q ? hi_hit : lo_hit;
	assign scan_found = ID_W'({rd_addr_s1[PTR_W-1:0], (hi_q ? hi_bit : lo_bit)});
	assign scan_end = hi_q ? PTR_W'(1) : PTR_W'(SCAN_BYTES - 1);

	// Sequencer, map valid bits and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
			op_claim_q <= 1'b0;
			bit_q <= '0;
			in_map_q <= 1'b0;
			hi_q <= 1'b0;
			scan_ptr_q <= '0;
			issue_done_q <= 1'b0;
			scan_vld_s1 <= 1'b0;
			scan_last_s1 <= 1'b0;
			rd_addr_s1 <= '0;
			res_found_q <= '0;
			res_ok_q <= 1'b0;
			out_valid_q <= 1'b0;
			found_ident_q <= '0;
			ok_q <= 1'b0;
		end else begin
			rd_addr_s1 <= raddr;
			// In ST_OUT an accepted result is replaced by the next one
			if (out_ready && state_q != ST_OUT) begin
				out_valid_q <= 1'b0;
			end
			if (ram_we) begin
				valid_q[rd_addr_s1] <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						op_claim_q <= op == OP_CLAIM;
						bit_q <= ident[BIT_W-1:0];
						in_map_q <= 32'(ident_byte) < MAP_BYTES;
						hi_q <= op == OP_FIND_HI;
						res_found_q <= '0;
						res_ok_q <= 1'b0;
						issue_done_q <= 1'b0;
						scan_vld_s1 <= 1'b0;
						scan_last_s1 <= 1'b0;
						unique case (op)
							OP_CLEAR: begin
								valid_q <= '0;
								res_ok_q <= 1'b1;
								state_q <= ST_OUT;
							end
							OP_CLAIM, OP_RELEASE: begin
								state_q <= ST_RMW;
							end
							OP_FIND_LO: begin
								scan_ptr_q <= '0;
								state_q <= ST_SCAN;
							end
							OP_FIND_HI: begin
								scan_ptr_q <= PTR_W'(SCAN_BYTES - 1);
								state_q <= ST_SCAN;
							end
							default: begin
								state_q <= ST_OUT;
							end
						endcase
					end
				end
				ST_RMW: begin
					res_ok_q <= op_claim_q ? (in_map_q && !bit_taken) : 1'b1;
					state_q <= ST_OUT;
				end
				ST_SCAN: begin
					if (scan_vld_s1 && (scan_hit || scan_last_s1)) begin
						res_found_q <= scan_hit ? scan_found : '0;
						res_ok_q <= scan_hit;
						state_q <= ST_OUT;
					end else begin
						scan_vld_s1 <= !issue_done_q;
						scan_last_s1 <= !issue_done_q && scan_ptr_q == scan_end;
						if (scan_ptr_q == scan_end) begin
							issue_done_q <= 1'b1;
						end else if (hi_q) begin
							scan_ptr_q <= scan_ptr_q - PTR_W'(1);
						end else begin
							scan_ptr_q <= scan_ptr_q + PTR_W'(1);
						end
					end
				end
				ST_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						found_ident_q <= res_found_q;
						ok_q <= res_ok_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready = state_q == ST_IDLE;
	assign out_valid = out_valid_q;
	assign found_ident = found_ident_q;
	assign ok = ok_q;

	// A found identifier always comes with success
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && found_ident != '0) |-> ok)
		else $error("found identifier without ok");

	// The map is written only during a claim or release
	a_we_rmw: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> state_q == ST_RMW)
		else $error("map write outside read-modify-write");

	// A written byte is marked valid afterwards
	a_we_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> valid_q[$past(rd_addr_s1)])
		else $error("written byte not marked valid");

	// The scan never reports id 0 from find-highest
	a_hi_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && hi_q && scan_vld_s1 && scan_hit) |-> scan_found[BIT_W-1:0] != '0)
		else $error("find-highest picked bit 0");

endmodule

`default_nettype wire
